[hdl/homography_square_sanity_check_assert.svh]
// ----------------------------------------------------------------------------
// Homography square sanity check: assertion macros
// Shared macros for concurrent assertions, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef HOMOGRAPHY_SQUARE_SANITY_CHECK_ASSERT_SVH
`define HOMOGRAPHY_SQUARE_SANITY_CHECK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/hssc_pkg.sv]
// ----------------------------------------------------------------------------
// hssc_pkg
// Types and widths shared by the homography square sanity check.
// ----------------------------------------------------------------------------
`default_nettype none

package hssc_pkg;

    // Coefficient width; the common fixed-point scale cancels in each ratio.
    localparam int COEFF_WIDTH = 32;

    // Corner numerator and denominator: sum of three coefficients.
    localparam int NUM_W       = COEFF_WIDTH + 2;
    // Quotient magnitude in Q15.16 below saturation.
    localparam int QUO_W       = 31;
    localparam int FRAC_W      = 16;
    localparam int REM_W       = NUM_W + FRAC_W;
    localparam int CMP_W       = NUM_W + QUO_W;

    localparam int NUM_LANES   = 8;
    localparam int NUM_CORNERS = 4;

    // Corner coordinates and the exact products built from them.
    localparam int CRD_W  = 32;
    localparam int DIF_W  = CRD_W + 1;
    localparam int PRD_W  = 2 * DIF_W;
    localparam int SUM_W  = PRD_W + 1;
    localparam int SQ_W   = 2 * CRD_W;
    localparam int LEN_W  = SQ_W + 1;
    localparam int LO_W   = 32;
    localparam int HI_W   = LEN_W - LO_W;
    localparam int PLL_W  = 2 * LO_W;
    localparam int PLH_W  = LO_W + HI_W;
    localparam int PHH_W  = 2 * HI_W;
    localparam int QUAD_W = 2 * LEN_W;

    // Limit register, Q1.15, and its square, Q2.30.
    localparam int COS_W   = 16;
    localparam int CSQ_W   = 2 * COS_W;
    localparam int SHIFT_Q = 2 * (COS_W - 1);
    localparam int NUM_PC  = 4;
    localparam int PC_W    = (QUAD_W + NUM_PC - 1) / NUM_PC;
    localparam int RP_W    = CSQ_W + PC_W;
    localparam int RHS_W   = QUAD_W + CSQ_W;

    localparam logic [COS_W-1:0] COS_LIMIT_RESET = 16'd31651;
    localparam logic [CSQ_W-1:0] COS_SQ_RESET    = 32'd1001785801;

    localparam logic signed [CRD_W-1:0] CRD_MAX = 32'sh7fffffff;
    localparam logic signed [CRD_W-1:0] CRD_MIN = 32'sh80000000;

    typedef struct packed {
        logic signed [COEFF_WIDTH-1:0] gain_xx;
        logic signed [COEFF_WIDTH-1:0] persp_x;
        logic signed [COEFF_WIDTH-1:0] gain_yx;
        logic signed [COEFF_WIDTH-1:0] gain_xy;
        logic signed [COEFF_WIDTH-1:0] gain_yy;
        logic signed [COEFF_WIDTH-1:0] persp_y;
        logic signed [COEFF_WIDTH-1:0] shift_x;
        logic signed [COEFF_WIDTH-1:0] shift_y;
        logic signed [COEFF_WIDTH-1:0] scale_w;
    } coef_t;

    typedef struct packed {
        logic accept;
        logic side_ok;
        logic angle_ok;
        logic degenerate;
    } res_t;

endpackage

`default_nettype wire

[hdl/homography_square_sanity_check.sv]
// ----------------------------------------------------------------------------
// homography_square_sanity_check
// Maps the unit square through a homography and checks the image for a
// convex, not too skewed quadrilateral.
// ----------------------------------------------------------------------------
// Usage:
// An input beat on coef (valid/ready) carries the nine homography
// coefficients. Each input beat produces exactly one result beat on res
// (valid/ready) with the accept, side_ok, angle_ok and degenerate flags.
// cfg (valid/ready, always ready) writes the cosine limit; it should only be
// written while no beat is in flight.
// The datapath is a 44-stage pipeline, one register stage per step: corner
// sums, magnitudes, a 32-stage restoring divider (one setup stage and one
// stage per quotient bit) for the eight coordinate quotients, then
// coordinates, differences, products, squares and the final compare.
// An accepted input beat passes through every stage in order to res, and
// one beat per cycle is sustained while res_ready is high. The 31 quotient
// bits, one per stage, set most of the latency.
// Every stage advances on its own when the next stage is empty or moving,
// so bubbles collapse. While the receiver stalls, input beats keep being
// taken until every stage is full; only then does coef_ready drop.
// Reset empties the pipeline and loads cos_limit with cos(15 degrees).
// ----------------------------------------------------------------------------
`default_nettype none

module homography_square_sanity_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           coef_valid,
    output logic                           coef_ready,
    input  hssc_pkg::coef_t                coef,
    output logic                           res_valid,
    input  logic                           res_ready,
    output hssc_pkg::res_t                 res,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hssc_pkg::COS_W-1:0]     cfg_data
);
    import hssc_pkg::*;

    // Stage numbering along the pipeline.
    localparam int ST_NUM   = 0;
    localparam int ST_MAG   = 1;
    localparam int ST_DIV0  = 2;
    localparam int ST_COORD = ST_DIV0 + QUO_W + 1;
    localparam int ST_DIFF  = ST_COORD + 1;
    localparam int ST_PROD  = ST_DIFF + 1;
    localparam int ST_SUM   = ST_PROD + 1;
    localparam int ST_ABS   = ST_SUM + 1;
    localparam int ST_SQP   = ST_ABS + 1;
    localparam int ST_SQS   = ST_SQP + 1;
    localparam int ST_RHP   = ST_SQS + 1;
    localparam int ST_RHS   = ST_RHP + 1;
    localparam int ST_OUT   = ST_RHS + 1;
    localparam int NST      = ST_OUT + 1;

    // Corner signs: A(-1,-1), B(1,-1), C(1,1), D(-1,1); a set bit means +1.
    localparam logic [NUM_CORNERS-1:0] CORNER_SX = 4'b0110;
    localparam logic [NUM_CORNERS-1:0] CORNER_SY = 4'b1100;

    // ------------------------------------------------------------------
    // Configuration. The squared limit is registered from the limit register and follows it in the next cycle.
    // ------------------------------------------------------------------
    logic [COS_W-1:0] cos_limit_reg;
    logic [CSQ_W-1:0] cos_sq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_limit_reg <= COS_LIMIT_RESET;
            cos_sq_reg    <= COS_SQ_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                cos_limit_reg <= cfg_data;
            end
            cos_sq_reg <= CSQ_W'(cos_limit_reg) * CSQ_W'(cos_limit_reg);
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its beat moves on.
    // ------------------------------------------------------------------
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST-1:0] stage_load;

    always_comb
    begin
        stage_load[NST-1] = !valid_reg[NST-1] || res_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            stage_load[i] = !valid_reg[i] || stage_load[i+1];
        end
        valid_next[0] = stage_load[0] ? coef_valid : valid_reg[0];
        for (int i = 1; i < NST; i++)
        begin
            valid_next[i] = stage_load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign coef_ready = stage_load[ST_NUM];
    assign res_valid  = valid_reg[ST_OUT];

    // ------------------------------------------------------------------
    // Corner numerators and denominators. Lane 2k is x of corner k, lane
    // 2k+1 is y of corner k.
    // ------------------------------------------------------------------
    logic signed [NUM_W-1:0] num_next [NUM_LANES];
    logic signed [NUM_W-1:0] den_next [NUM_CORNERS];
    logic signed [NUM_W-1:0] num_reg  [NUM_LANES];
    logic signed [NUM_W-1:0] den_reg  [NUM_CORNERS];

    always_comb
    begin
        logic signed [NUM_W-1:0] h0, h1, h2, h3, h4, h5, h6, h7, h8;
        h0 = NUM_W'(coef.gain_xx);
        h1 = NUM_W'(coef.gain_yx);
        h2 = NUM_W'(coef.persp_x);
        h3 = NUM_W'(coef.gain_xy);
        h4 = NUM_W'(coef.gain_yy);
        h5 = NUM_W'(coef.persp_y);
        h6 = NUM_W'(coef.shift_x);
        h7 = NUM_W'(coef.shift_y);
        h8 = NUM_W'(coef.scale_w);
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            num_next[2*k]   = (CORNER_SX[k] ? h0 : -h0) + (CORNER_SY[k] ? h3 : -h3) + h6;
            num_next[2*k+1] = (CORNER_SX[k] ? h1 : -h1) + (CORNER_SY[k] ? h4 : -h4) + h7;
            den_next[k]     = (CORNER_SX[k] ? h2 : -h2) + (CORNER_SY[k] ? h5 : -h5) + h8;
        end
    end

    // Magnitudes and quotient signs.
    logic [NUM_W-1:0]       nmag_reg [NUM_LANES];
    logic [NUM_W-1:0]       dmag_reg [NUM_LANES];
    logic [NUM_LANES-1:0]   neg_reg;
    logic [NUM_CORNERS-1:0] dz_reg;

    always_ff @(posedge clk)
    begin
        if (stage_load[ST_NUM])
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
        if (stage_load[ST_MAG])
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                neg_reg[l]  <= num_reg[l][NUM_W-1] ^ den_reg[l>>1][NUM_W-1];
                nmag_reg[l] <= num_reg[l][NUM_W-1] ? NUM_W'(-num_reg[l])
                                                   : NUM_W'(num_reg[l]);
                dmag_reg[l] <= den_reg[l>>1][NUM_W-1] ? NUM_W'(-den_reg[l>>1])
                                                      : NUM_W'(den_reg[l>>1]);
            end
            for (int k = 0; k < NUM_CORNERS; k++)
            begin
                dz_reg[k] <= (den_reg[k] == '0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider, one quotient bit per stage. Row 0 holds the
    // saturation check and the scaled dividend; row j resolves bit QUO_W-j.
    // The remainder is not shifted: it is compared against the divisor
    // shifted up to the bit being resolved.
    // ------------------------------------------------------------------
    logic [REM_W-1:0]       rem_reg  [QUO_W+1][NUM_LANES];
    logic [QUO_W-1:0]       quo_reg  [QUO_W+1][NUM_LANES];
    logic [NUM_W-1:0]       dvs_reg  [QUO_W+1][NUM_LANES];
    logic [NUM_LANES-1:0]   sat_reg  [QUO_W+1];
    logic [NUM_LANES-1:0]   sgn_reg  [QUO_W+1];
    logic [NUM_CORNERS-1:0] dzd_reg  [QUO_W+1];
    logic [REM_W-1:0]       rem_next [1:QUO_W][NUM_LANES];
    logic [QUO_W-1:0]       quo_next [1:QUO_W][NUM_LANES];

    always_comb
    begin
        logic [CMP_W-1:0] dsh;
        logic             ge;
        for (int j = 1; j <= QUO_W; j++)
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                dsh = CMP_W'(dvs_reg[j-1][l]) << (QUO_W - j);
                ge  = CMP_W'(rem_reg[j-1][l]) >= dsh;
                rem_next[j][l] = ge ? REM_W'(CMP_W'(rem_reg[j-1][l]) - dsh)
                                    : rem_reg[j-1][l];
                quo_next[j][l] = quo_reg[j-1][l]
                               | (ge ? (QUO_W'(1) << (QUO_W - j)) : QUO_W'(0));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[ST_DIV0])
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                rem_reg[0][l] <= REM_W'(nmag_reg[l]) << FRAC_W;
                quo_reg[0][l] <= '0;
                dvs_reg[0][l] <= dmag_reg[l];
                // The integer part reaches 2^15 exactly when n >= d * 2^15.
                sat_reg[0][l] <= CMP_W'(nmag_reg[l])
                                 >= (CMP_W'(dmag_reg[l]) << (QUO_W - FRAC_W));
            end
            sgn_reg[0] <= neg_reg;
            dzd_reg[0] <= dz_reg;
        end
        for (int j = 1; j <= QUO_W; j++)
        begin
            if (stage_load[ST_DIV0 + j])
            begin
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    rem_reg[j][l] <= rem_next[j][l];
                    quo_reg[j][l] <= quo_next[j][l];
                    dvs_reg[j][l] <= dvs_reg[j-1][l];
                end
                sat_reg[j] <= sat_reg[j-1];
                sgn_reg[j] <= sgn_reg[j-1];
                dzd_reg[j] <= dzd_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Geometry: coordinates, differences, products, exact compare.
    // ------------------------------------------------------------------
    logic signed [CRD_W-1:0] crd_reg [NUM_LANES];
    logic                    dz_c_reg;
    logic signed [DIF_W-1:0] acx_reg, acy_reg, bdx_reg, bdy_reg;
    logic signed [DIF_W-1:0] abx_reg, aby_reg, adx_reg, ady_reg;
    logic                    dz_f_reg;
    logic signed [PRD_W-1:0] pb1_reg, pb2_reg, pd1_reg, pd2_reg, pt1_reg, pt2_reg;
    logic [SQ_W-1:0]         sqax_reg, sqay_reg, sqbx_reg, sqby_reg;
    logic signed [SUM_W-1:0] dot_reg;
    logic [LEN_W-1:0]        lac_reg, lbd_reg, lac_a_reg, lbd_a_reg, dmag_len_reg;
    logic [PLL_W-1:0]        dll_reg, ll_reg;
    logic [PLH_W-1:0]        dlh_reg, lh_reg, hl_reg;
    logic [PHH_W-1:0]        dhh_reg, hh_reg;
    logic [QUAD_W-1:0]       dsq_reg, pr_reg, dsq_r_reg;
    logic [RP_W-1:0]         rp_reg [NUM_PC];
    logic [RHS_W-1:0]        lhs_reg, rhs_reg;
    logic                    side_reg  [ST_SUM:ST_RHS];
    logic                    degen_reg [ST_PROD:ST_RHS];
    res_t                    res_reg;

    logic signed [SUM_W-1:0] vb, vd;
    logic                    side_now;
    logic [RHS_W-1:0]        rhs_sum;
    logic                    side_fin, angle_fin;

    always_comb
    begin
        vb       = SUM_W'(pb1_reg) - SUM_W'(pb2_reg);
        vd       = SUM_W'(pd1_reg) - SUM_W'(pd2_reg);
        // B strictly on the positive side and D strictly on the negative side.
        side_now = !vb[SUM_W-1] && (vb != '0) && vd[SUM_W-1];
        rhs_sum  = '0;
        for (int i = 0; i < NUM_PC; i++)
        begin
            rhs_sum = rhs_sum + (RHS_W'(rp_reg[i]) << (i * PC_W));
        end
        side_fin  = side_reg[ST_RHS] && !degen_reg[ST_RHS];
        angle_fin = (lhs_reg <= rhs_reg) && !degen_reg[ST_RHS];
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[ST_COORD])
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                crd_reg[l] <= sat_reg[QUO_W][l]
                              ? (sgn_reg[QUO_W][l] ? CRD_MIN : CRD_MAX)
                              : (sgn_reg[QUO_W][l] ? -CRD_W'(quo_reg[QUO_W][l])
                                                   : CRD_W'(quo_reg[QUO_W][l]));
            end
            dz_c_reg <= |dzd_reg[QUO_W];
        end
        if (stage_load[ST_DIFF])
        begin
            acx_reg  <= DIF_W'(crd_reg[4]) - DIF_W'(crd_reg[0]);
            acy_reg  <= DIF_W'(crd_reg[5]) - DIF_W'(crd_reg[1]);
            bdx_reg  <= DIF_W'(crd_reg[2]) - DIF_W'(crd_reg[6]);
            bdy_reg  <= DIF_W'(crd_reg[3]) - DIF_W'(crd_reg[7]);
            abx_reg  <= DIF_W'(crd_reg[2]) - DIF_W'(crd_reg[0]);
            aby_reg  <= DIF_W'(crd_reg[3]) - DIF_W'(crd_reg[1]);
            adx_reg  <= DIF_W'(crd_reg[6]) - DIF_W'(crd_reg[0]);
            ady_reg  <= DIF_W'(crd_reg[7]) - DIF_W'(crd_reg[1]);
            dz_f_reg <= dz_c_reg;
        end
        if (stage_load[ST_PROD])
        begin
            pb1_reg  <= PRD_W'(acy_reg) * PRD_W'(abx_reg);
            pb2_reg  <= PRD_W'(acx_reg) * PRD_W'(aby_reg);
            pd1_reg  <= PRD_W'(acy_reg) * PRD_W'(adx_reg);
            pd2_reg  <= PRD_W'(acx_reg) * PRD_W'(ady_reg);
            pt1_reg  <= PRD_W'(acx_reg) * PRD_W'(bdx_reg);
            pt2_reg  <= PRD_W'(acy_reg) * PRD_W'(bdy_reg);
            sqax_reg <= SQ_W'(PRD_W'(acx_reg) * PRD_W'(acx_reg));
            sqay_reg <= SQ_W'(PRD_W'(acy_reg) * PRD_W'(acy_reg));
            sqbx_reg <= SQ_W'(PRD_W'(bdx_reg) * PRD_W'(bdx_reg));
            sqby_reg <= SQ_W'(PRD_W'(bdy_reg) * PRD_W'(bdy_reg));
            degen_reg[ST_PROD] <= dz_f_reg
                                  || ((acx_reg == '0) && (acy_reg == '0))
                                  || ((bdx_reg == '0) && (bdy_reg == '0));
        end
        if (stage_load[ST_SUM])
        begin
            side_reg[ST_SUM] <= side_now;
            dot_reg          <= SUM_W'(pt1_reg) + SUM_W'(pt2_reg);
            lac_reg          <= LEN_W'(sqax_reg) + LEN_W'(sqay_reg);
            lbd_reg          <= LEN_W'(sqbx_reg) + LEN_W'(sqby_reg);
        end
        if (stage_load[ST_ABS])
        begin
            dmag_len_reg <= LEN_W'(dot_reg[SUM_W-1] ? -dot_reg : dot_reg);
            lac_a_reg    <= lac_reg;
            lbd_a_reg    <= lbd_reg;
        end
        if (stage_load[ST_SQP])
        begin
            dll_reg <= PLL_W'(dmag_len_reg[LO_W-1:0]) * PLL_W'(dmag_len_reg[LO_W-1:0]);
            dlh_reg <= PLH_W'(dmag_len_reg[LO_W-1:0]) * PLH_W'(dmag_len_reg[LEN_W-1:LO_W]);
            dhh_reg <= PHH_W'(dmag_len_reg[LEN_W-1:LO_W])
                       * PHH_W'(dmag_len_reg[LEN_W-1:LO_W]);
            ll_reg  <= PLL_W'(lac_a_reg[LO_W-1:0]) * PLL_W'(lbd_a_reg[LO_W-1:0]);
            lh_reg  <= PLH_W'(lac_a_reg[LO_W-1:0]) * PLH_W'(lbd_a_reg[LEN_W-1:LO_W]);
            hl_reg  <= PLH_W'(lac_a_reg[LEN_W-1:LO_W]) * PLH_W'(lbd_a_reg[LO_W-1:0]);
            hh_reg  <= PHH_W'(lac_a_reg[LEN_W-1:LO_W]) * PHH_W'(lbd_a_reg[LEN_W-1:LO_W]);
        end
        if (stage_load[ST_SQS])
        begin
            // The cross term of a square appears twice, hence one extra shift.
            dsq_reg <= QUAD_W'(dll_reg)
                       + (QUAD_W'(dlh_reg) << (LO_W + 1))
                       + (QUAD_W'(dhh_reg) << (2 * LO_W));
            pr_reg  <= QUAD_W'(ll_reg)
                       + ((QUAD_W'(lh_reg) + QUAD_W'(hl_reg)) << LO_W)
                       + (QUAD_W'(hh_reg) << (2 * LO_W));
        end
        if (stage_load[ST_RHP])
        begin
            for (int i = 0; i < NUM_PC; i++)
            begin
                rp_reg[i] <= RP_W'(cos_sq_reg) * RP_W'(PC_W'(pr_reg >> (i * PC_W)));
            end
            dsq_r_reg <= dsq_reg;
        end
        if (stage_load[ST_RHS])
        begin
            lhs_reg <= RHS_W'(dsq_r_reg) << SHIFT_Q;
            rhs_reg <= rhs_sum;
        end
        for (int s = ST_SUM + 1; s <= ST_RHS; s++)
        begin
            if (stage_load[s])
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
        for (int s = ST_PROD + 1; s <= ST_RHS; s++)
        begin
            if (stage_load[s])
            begin
                degen_reg[s] <= degen_reg[s-1];
            end
        end
        if (stage_load[ST_OUT])
        begin
            res_reg.accept     <= side_fin && angle_fin;
            res_reg.side_ok    <= side_fin;
            res_reg.angle_ok   <= angle_fin;
            res_reg.degenerate <= degen_reg[ST_RHS];
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

[hdl/hssc_checker.sv]
// ----------------------------------------------------------------------------
// hssc_checker
// Port-level checks for the homography square sanity check, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "homography_square_sanity_check_assert.svh"

module hssc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           coef_ready,
    input logic           res_valid,
    input logic           res_ready,
    input hssc_pkg::res_t res
);

    // A stalled result beat holds its value.
    `HSSC_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res), "result beat changed while stalled")

    // The input side only backs up when the output side is stalled.
    `HSSC_ASSERT_NOW(a_backpressure, clk, rst_n, !coef_ready, res_valid && !res_ready, "input stalled without output stall")

    // A degenerate mapping passes no test.
    `HSSC_ASSERT_NOW(a_degen_fail, clk, rst_n, res_valid && res.degenerate, !res.accept && !res.side_ok && !res.angle_ok, "degenerate result passed a test")

    // Acceptance needs both tests.
    `HSSC_ASSERT_NOW(a_accept_both, clk, rst_n, res_valid && res.accept, res.side_ok && res.angle_ok, "accept without both tests")

endmodule

bind homography_square_sanity_check hssc_checker u_hssc_checker (.*);

`default_nettype wire

[test/tb_homography_square_sanity_check.sv]
// ----------------------------------------------------------------------------
// Homography square sanity check testbench
// Sends homographies through the block with random gaps, back-pressure and
// one long receiver stall. A local predictor with exact wide arithmetic
// works out each verdict, and every result beat is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_homography_square_sanity_check;
    import hssc_pkg::*;

    // Wide enough for the largest product in the angle compare.
    typedef logic signed [199:0] wide_t;

    localparam int  MAX_GAP    = 17;
    localparam int  DRAIN_WAIT = 60;
    localparam int  CYCLE_CAP  = 600000;
    localparam int  LONG_STALL = 400;
    localparam int  Q24_ONE    = 32'h0100_0000;

    logic             clk;
    logic             rst_n;
    logic             coef_valid;
    logic             coef_ready;
    coef_t            coef;
    logic             res_valid;
    logic             res_ready;
    res_t             res;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [COS_W-1:0] cfg_data;

    // Local copy of the limit register, updated on every config beat.
    logic [COS_W-1:0] limit_shadow;
    res_t             verdict_q[$];
    int               error_count = 0;
    int               cycle_count = 0;
    int               gap_max;        // Zero gives stretches with no idling.
    int               stall_request;  // Asks the receiver for a long hold-off.

    homography_square_sanity_check u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_valid (coef_valid),
        .coef_ready (coef_ready),
        .coef       (coef),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The run is cut off if it ever takes far longer than the slowest
    // correct run could.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Q16.16 quotient, truncated toward zero and saturated to 32 bits.
    function automatic longint corner_quotient(input longint num, input longint den);
        longint n;
        longint d;
        longint q;
        bit     neg;
        n   = (num < 0) ? -num : num;
        d   = (den < 0) ? -den : den;
        neg = (num < 0) != (den < 0);
        if (n / d >= 32768)
            return neg ? -64'sd2147483648 : 64'sd2147483647;
        q = (n << 16) / d;
        return neg ? -q : q;
    endfunction

    // Verdict for one homography under the given cosine limit.
    function automatic res_t square_verdict(input coef_t c, input logic [COS_W-1:0] lim);
        longint h[9];
        longint px[4];
        longint py[4];
        int     sx[4];
        int     sy[4];
        longint den;
        longint acx, acy, bdx, bdy;
        wide_t  w_acx, w_acy, w_bdx, w_bdy, side_b, side_d, dot, lhs, rhs, lac, lbd, wl;
        bit     degen;
        res_t   r;
        sx = '{-1, 1, 1, -1};
        sy = '{-1, -1, 1, 1};
        h[0] = c.gain_xx; h[1] = c.gain_yx; h[2] = c.persp_x;
        h[3] = c.gain_xy; h[4] = c.gain_yy; h[5] = c.persp_y;
        h[6] = c.shift_x; h[7] = c.shift_y; h[8] = c.scale_w;
        degen = 1'b0;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            den = sx[k] * h[2] + sy[k] * h[5] + h[8];
            if (den == 0)
            begin
                degen = 1'b1;
                px[k] = 0;
                py[k] = 0;
            end
            else
            begin
                px[k] = corner_quotient(sx[k] * h[0] + sy[k] * h[3] + h[6], den);
                py[k] = corner_quotient(sx[k] * h[1] + sy[k] * h[4] + h[7], den);
            end
        end
        acx = px[2] - px[0];
        acy = py[2] - py[0];
        bdx = px[1] - px[3];
        bdy = py[1] - py[3];
        if ((acx == 0 && acy == 0) || (bdx == 0 && bdy == 0))
            degen = 1'b1;
        r = '0;
        r.degenerate = degen;
        if (!degen)
        begin
            w_acx = acx;
            w_acy = acy;
            w_bdx = bdx;
            w_bdy = bdy;
            side_b = w_acy * wide_t'(px[1] - px[0]) - w_acx * wide_t'(py[1] - py[0]);
            side_d = w_acy * wide_t'(px[3] - px[0]) - w_acx * wide_t'(py[3] - py[0]);
            r.side_ok = (side_b > 0) && (side_d < 0);
            dot = w_acx * w_bdx + w_acy * w_bdy;
            lhs = (dot * dot) <<< 30;
            lac = w_acx * w_acx + w_acy * w_acy;
            lbd = w_bdx * w_bdx + w_bdy * w_bdy;
            wl  = {184'd0, lim};
            rhs = wl * wl * lac * lbd;
            r.angle_ok = lhs <= rhs;
            r.accept   = r.side_ok && r.angle_ok;
        end
        return r;
    endfunction

    // Offers one beat after a random gap and holds it until accepted. The
    // expected verdict is queued at the accepting edge.
    task automatic send_homography(input coef_t c);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            coef_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        coef_valid <= 1'b1;
        coef       <= c;
        do
            @(posedge clk);
        while (!coef_ready);
        verdict_q.push_back(square_verdict(c, limit_shadow));
    endtask

    // Waits until every verdict has come back, then lets the pipeline settle.
    task automatic drain_pipeline();
        coef_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_cos_limit(input logic [COS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        limit_shadow = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic coef_t make_coef(input int a0, a2, a1, a3, a4, a5, a6, a7, a8);
        coef_t c;
        c.gain_xx = a0; c.persp_x = a2; c.gain_yx = a1;
        c.gain_xy = a3; c.gain_yy = a4; c.persp_y = a5;
        c.shift_x = a6; c.shift_y = a7; c.scale_w = a8;
        return c;
    endfunction

    // Small signed jitter around a Q8.24 value.
    function automatic int jitter(input int base, input int span);
        return base + int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Mostly plausible homographies: a random affine map with a mild
    // perspective part, sometimes mirrored or squashed. The rest is raw noise
    // and small integer matrices that hit zero denominators and collinear
    // corners.
    function automatic coef_t random_homography();
        coef_t c;
        int    pick;
        int    s;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            s = (pick == 0) ? -Q24_ONE : Q24_ONE;
            c = make_coef(jitter(s, 1 << 24), jitter(0, 1 << 21), jitter(0, 1 << 24),
                          jitter(0, 1 << 24), jitter(Q24_ONE, 1 << 24),
                          jitter(0, 1 << 21), jitter(0, 1 << 26), jitter(0, 1 << 26),
                          jitter(Q24_ONE, 1 << 22));
        end
        else if (pick < 8)
        begin
            c = coef_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom});
        end
        else
        begin
            c = make_coef(jitter(0, 3), jitter(0, 1), jitter(0, 3), jitter(0, 3),
                          jitter(0, 3), jitter(0, 1), jitter(0, 3), jitter(0, 3),
                          jitter(0, 2));
        end
        return c;
    endfunction

    // Result side: checks each beat against the oldest verdict and draws a
    // fresh stall after each beat. A stall request from a test overrides it.
    initial
    begin : result_checker
        int   hold;
        res_t want;
        hold      = 0;
        res_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_valid && res_ready)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch("result beat with no verdict pending");
                else
                begin
                    want = verdict_q.pop_front();
                    if (res.accept !== want.accept)
                        report_mismatch($sformatf("accept %b, want %b", res.accept,
                                                  want.accept));
                    if (res.side_ok !== want.side_ok)
                        report_mismatch($sformatf("side_ok %b, want %b", res.side_ok,
                                                  want.side_ok));
                    if (res.angle_ok !== want.angle_ok)
                        report_mismatch($sformatf("angle_ok %b, want %b", res.angle_ok,
                                                  want.angle_ok));
                    if (res.degenerate !== want.degenerate)
                        report_mismatch($sformatf("degenerate %b, want %b",
                                                  res.degenerate, want.degenerate));
                end
                hold = $urandom_range(0, gap_max);
            end
            if (stall_request > 0)
            begin
                hold          = stall_request;
                stall_request = 0;
            end
            if (hold > 0)
            begin
                res_ready <= 1'b0;
                hold--;
            end
            else
                res_ready <= 1'b1;
        end
    end

    // Corner cases: identity, mirror, collapse, zero denominators, field
    // extremes, saturation and a strongly sheared square.
    task automatic test_directed();
        send_homography(make_coef(Q24_ONE, 0, 0, 0, Q24_ONE, 0, 0, 0, Q24_ONE));
        send_homography(make_coef(-Q24_ONE, 0, 0, 0, Q24_ONE, 0, 0, 0, Q24_ONE));
        send_homography(make_coef(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_homography(make_coef(0, 0, 0, 0, 0, 0, Q24_ONE, Q24_ONE, Q24_ONE));
        send_homography(make_coef(Q24_ONE, Q24_ONE, 0, 0, Q24_ONE, 0, 0, 0, Q24_ONE));
        send_homography(make_coef(Q24_ONE, 0, 0, 0, Q24_ONE, 0, 0, 0, 1));
        send_homography(make_coef(Q24_ONE, 0, 0, Q24_ONE, Q24_ONE, 0, 0, 0, Q24_ONE));
        send_homography(make_coef(Q24_ONE, 0, Q24_ONE, 0, Q24_ONE, 0, 0, 0, Q24_ONE));
        send_homography(make_coef(Q24_ONE, 0, 0, 0, 0, 0, 0, 0, Q24_ONE));
        send_homography(make_coef(2, 0, 0, 0, 3, 0, 0, 0, 1));
        send_homography(coef_t'({9{32'h7fff_ffff}}));
        send_homography(coef_t'({9{32'h8000_0000}}));
        send_homography(coef_t'({9{32'hffff_ffff}}));
        send_homography(make_coef(32'h7fff_ffff, 0, 0, 0, 32'h8000_0000, 0,
                                  32'h7fff_ffff, 32'h8000_0000, 1));
        send_homography(make_coef(Q24_ONE, 32'h7fff_ffff, 0, 0, Q24_ONE,
                                  32'h8000_0000, 0, 0, 32'h7fff_ffff));
        send_homography(make_coef(Q24_ONE, Q24_ONE / 2, 0, 0, Q24_ONE,
                                  Q24_ONE / 2, 0, 0, Q24_ONE));
        drain_pipeline();
    endtask

    task automatic test_random(input int count);
        repeat (count) send_homography(random_homography());
        drain_pipeline();
    endtask

    // The receiver holds off for a long stretch while beats keep coming
    // back to back, so the pipeline fills and coef_ready must drop.
    task automatic test_backpressure();
        gap_max       = 0;
        stall_request = LONG_STALL;
        repeat (80) send_homography(random_homography());
        drain_pipeline();
        gap_max = MAX_GAP;
    endtask

    // Several limits, the extremes among them, each with its own batch.
    task automatic test_cos_limit_sweep();
        logic [COS_W-1:0] limits[6];
        limits = '{16'd0, 16'd32768, 16'd65535, 16'd1, 16'd23170, 16'd32767};
        foreach (limits[i])
        begin
            write_cos_limit(limits[i]);
            test_random(40);
        end
        write_cos_limit(COS_LIMIT_RESET);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        coef_valid    = 1'b0;
        coef          = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        limit_shadow  = COS_LIMIT_RESET;
        gap_max       = MAX_GAP;
        stall_request = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(120);
        test_backpressure();
        gap_max = 0;
        test_random(60);
        gap_max = MAX_GAP;
        test_cos_limit_sweep();

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
